// File: rtl/cabs_pkg.sv
// shared types, codes and constants of the conditional alu with barrel shifter
package cabs_pkg;

    localparam int DATA_W  = 32;
    localparam int FLAG_W  = 4;
    localparam int REG_W   = 4;
    localparam int AMT_W   = 5;
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 48;

    // condition codes
    localparam logic [3:0] COND_EQ = 4'h0;
    localparam logic [3:0] COND_NE = 4'h1;
    localparam logic [3:0] COND_GE = 4'hA;
    localparam logic [3:0] COND_LT = 4'hB;
    localparam logic [3:0] COND_GT = 4'hC;
    localparam logic [3:0] COND_LE = 4'hD;
    localparam logic [3:0] COND_AL = 4'hE;

    // opcodes
    localparam logic [3:0] OP_AND = 4'h0;
    localparam logic [3:0] OP_EOR = 4'h1;
    localparam logic [3:0] OP_SUB = 4'h2;
    localparam logic [3:0] OP_RSB = 4'h3;
    localparam logic [3:0] OP_ADD = 4'h4;
    localparam logic [3:0] OP_TST = 4'h8;
    localparam logic [3:0] OP_TEQ = 4'h9;
    localparam logic [3:0] OP_CMP = 4'hA;
    localparam logic [3:0] OP_ORR = 4'hC;
    localparam logic [3:0] OP_MOV = 4'hD;

    // shift type field of the instruction
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // flag bit positions
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    // normalized shifter operation
    typedef logic [2:0] t_shkind;
    localparam t_shkind KIND_LSL  = 3'd0;
    localparam t_shkind KIND_LSR  = 3'd1;
    localparam t_shkind KIND_ASR  = 3'd2;
    localparam t_shkind KIND_ROR  = 3'd3;
    localparam t_shkind KIND_PASS = 3'd4;
    localparam t_shkind KIND_RRX  = 3'd5;
    localparam t_shkind KIND_ZERO = 3'd6;
    localparam t_shkind KIND_SIGN = 3'd7;

    typedef struct packed {
        logic                exec;
        logic [3:0]          opcode;
        logic                s;
        logic [REG_W-1:0]    rd;
        logic [DATA_W-1:0]   rn;
        logic [FLAG_W-1:0]   flags;
        logic [DATA_W-1:0]   sh_val;
        t_shkind             kind;
        logic [AMT_W-1:0]    amt;
        logic                zero_c;
    } t_dec;

    typedef struct packed {
        logic                exec;
        logic [3:0]          opcode;
        logic                s;
        logic [REG_W-1:0]    rd;
        logic [DATA_W-1:0]   rn;
        logic [FLAG_W-1:0]   flags;
        logic [DATA_W-1:0]   op2;
        logic                sc;
    } t_opnd;

    typedef struct packed {
        logic                executed;
        logic                write_enable;
        logic [REG_W-1:0]    dest_register;
        logic [DATA_W-1:0]   result_value;
        logic [FLAG_W-1:0]   flags_out;
    } t_res;

endpackage

// File: rtl/conditional_alu_with_barrel_shift.sv
// top level: three-stage conditional data-processing alu with barrel shifter
// The block takes one data-processing instruction with its Rn, Rm and Rs
// values and the NZCV flags per cycle while the output register can move on,
// and returns one result item for each, in order: stage one checks the
// condition and decodes the shift, stage two runs the barrel shifter, stage
// three runs the adder and logic unit and holds the result as the output
// register. All stages advance together whenever the output register is
// empty or its item is taken, so s_axis_tready follows m_axis_tready while
// an item is waiting. There is no configuration and no state between items.
module conditional_alu_with_barrel_shift (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // instruction, rn_value, rm_value, rs_value, flags_in, zero pad
    input  logic [cabs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // executed, write_enable, dest_register, result_value, flags_out, zero pad
    output logic [cabs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import cabs_pkg::*;

    logic  en;
    logic  v1;
    logic  v2;
    logic  v3;
    t_dec  d1;
    t_opnd d2;
    t_res  d3;

    assign en            = !v3 || m_axis_tready;
    assign s_axis_tready = en;

    cabs_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (s_axis_tvalid),
        .i_instruction (s_axis_tdata[31:0]),
        .i_rn_value    (s_axis_tdata[63:32]),
        .i_rm_value    (s_axis_tdata[95:64]),
        .i_rs_value    (s_axis_tdata[127:96]),
        .i_flags_in    (s_axis_tdata[131:128]),
        .o_valid       (v1),
        .o_data        (d1)
    );

    cabs_shift u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v1),
        .i_data  (d1),
        .o_valid (v2),
        .o_data  (d2)
    );

    cabs_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v2),
        .i_data  (d2),
        .o_valid (v3),
        .o_data  (d3)
    );

    assign m_axis_tvalid = v3;
    assign m_axis_tdata  = {6'b0, d3.flags_out, d3.result_value, d3.dest_register,
                            d3.write_enable, d3.executed};

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 en ##1 en |=> m_axis_tvalid)
        else $error("accepted item did not reach the output");

    a_pad_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:42] == '0)
        else $error("output pad bits not zero");

    a_pipe_moves : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v2 && en |=> v3)
        else $error("item lost between shifter and alu");

endmodule

// File: rtl/cabs_decode.sv
// stage one: condition check and shifter operation decode
module cabs_decode (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [cabs_pkg::DATA_W-1:0] i_instruction,
    input  logic [cabs_pkg::DATA_W-1:0] i_rn_value,
    input  logic [cabs_pkg::DATA_W-1:0] i_rm_value,
    input  logic [cabs_pkg::DATA_W-1:0] i_rs_value,
    input  logic [cabs_pkg::FLAG_W-1:0] i_flags_in,
    output logic                        o_valid,
    output cabs_pkg::t_dec              o_data
);
    import cabs_pkg::*;

    logic   r_valid;
    t_dec   r_data;
    t_dec   n_data;
    logic   cond_ok;
    logic   f_n;
    logic   f_z;
    logic   f_v;
    logic [3:0] rot;
    logic [1:0] sh_type;
    logic [4:0] imm_amt;
    logic [7:0] rs8;

    assign f_n     = i_flags_in[FLAG_N];
    assign f_z     = i_flags_in[FLAG_Z];
    assign f_v     = i_flags_in[FLAG_V];
    assign rot     = i_instruction[11:8];
    assign sh_type = i_instruction[6:5];
    assign imm_amt = i_instruction[11:7];
    assign rs8     = i_rs_value[7:0];

    always_comb begin
        case (i_instruction[31:28])
            COND_EQ: cond_ok = f_z;
            COND_NE: cond_ok = !f_z;
            COND_GE: cond_ok = (f_n == f_v);
            COND_LT: cond_ok = (f_n != f_v);
            COND_GT: cond_ok = !f_z && (f_n == f_v);
            COND_LE: cond_ok = f_z || (f_n != f_v);
            COND_AL: cond_ok = 1'b1;
            default: cond_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_data.exec   = cond_ok;
        n_data.opcode = i_instruction[24:21];
        n_data.s      = i_instruction[20];
        n_data.rd     = i_instruction[15:12];
        n_data.rn     = i_rn_value;
        n_data.flags  = i_flags_in;
        n_data.sh_val = i_rm_value;
        n_data.kind   = KIND_PASS;
        n_data.amt    = '0;
        n_data.zero_c = 1'b0;
        if (i_instruction[25]) begin
            // rotated immediate
            n_data.sh_val = {{(DATA_W-8){1'b0}}, i_instruction[7:0]};
            n_data.amt    = {rot, 1'b0};
            n_data.kind   = (rot == 4'd0) ? KIND_PASS : KIND_ROR;
        end else if (!i_instruction[4]) begin
            // shift by constant
            if (imm_amt == 5'd0) begin
                case (sh_type)
                    SH_LSL: n_data.kind = KIND_PASS;
                    SH_LSR: begin
                        n_data.kind   = KIND_ZERO;
                        n_data.zero_c = i_rm_value[DATA_W-1];
                    end
                    SH_ASR: n_data.kind = KIND_SIGN;
                    default: n_data.kind = KIND_RRX;
                endcase
            end else begin
                n_data.kind = {1'b0, sh_type};
                n_data.amt  = imm_amt;
            end
        end else begin
            // shift by register
            if (rs8 == 8'd0) begin
                n_data.kind = KIND_PASS;
            end else if (rs8[7:5] != 3'd0) begin
                case (sh_type)
                    SH_LSL: begin
                        n_data.kind   = KIND_ZERO;
                        n_data.zero_c = (rs8 == 8'd32) && i_rm_value[0];
                    end
                    SH_LSR: begin
                        n_data.kind   = KIND_ZERO;
                        n_data.zero_c = (rs8 == 8'd32) && i_rm_value[DATA_W-1];
                    end
                    SH_ASR: n_data.kind = KIND_SIGN;
                    default: begin
                        n_data.kind = KIND_ROR;
                        n_data.amt  = rs8[4:0];
                    end
                endcase
            end else begin
                n_data.kind = {1'b0, sh_type};
                n_data.amt  = rs8[4:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/cabs_shift.sv
// stage two: barrel shifter producing operand2 and the shifter carry
module cabs_shift (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  cabs_pkg::t_dec  i_data,
    output logic            o_valid,
    output cabs_pkg::t_opnd o_data
);
    import cabs_pkg::*;

    logic                r_valid;
    t_opnd               r_data;
    t_opnd               n_data;
    logic [DATA_W:0]     t33;
    logic [2*DATA_W-1:0] t64;
    logic [DATA_W-1:0]   v;
    logic                cin;
    logic [DATA_W-1:0]   res;
    logic                c;

    assign v   = i_data.sh_val;
    assign cin = i_data.flags[FLAG_C];

    always_comb begin
        t33 = '0;
        t64 = '0;
        res = v;
        c   = cin;
        case (i_data.kind)
            KIND_LSL: begin
                t33 = {1'b0, v} << i_data.amt;
                res = t33[DATA_W-1:0];
                c   = t33[DATA_W];
            end
            KIND_LSR: begin
                t33 = {v, 1'b0} >> i_data.amt;
                res = t33[DATA_W:1];
                c   = t33[0];
            end
            KIND_ASR: begin
                t33 = $signed({v, 1'b0}) >>> i_data.amt;
                res = t33[DATA_W:1];
                c   = t33[0];
            end
            KIND_ROR: begin
                t64 = {v, v} >> i_data.amt;
                res = t64[DATA_W-1:0];
                c   = t64[DATA_W-1];
            end
            KIND_RRX: begin
                res = {cin, v[DATA_W-1:1]};
                c   = v[0];
            end
            KIND_ZERO: begin
                res = '0;
                c   = i_data.zero_c;
            end
            KIND_SIGN: begin
                res = {DATA_W{v[DATA_W-1]}};
                c   = v[DATA_W-1];
            end
            default: begin
                res = v;
                c   = cin;
            end
        endcase
    end

    always_comb begin
        n_data.exec   = i_data.exec;
        n_data.opcode = i_data.opcode;
        n_data.s      = i_data.s;
        n_data.rd     = i_data.rd;
        n_data.rn     = i_data.rn;
        n_data.flags  = i_data.flags;
        n_data.op2    = res;
        n_data.sc     = c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/cabs_alu.sv
// stage three: alu operation, register write and flag update
module cabs_alu (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  cabs_pkg::t_opnd i_data,
    output logic            o_valid,
    output cabs_pkg::t_res  o_data
);
    import cabs_pkg::*;

    logic              r_valid;
    t_res              r_data;
    t_res              n_data;
    logic [DATA_W-1:0] add_a;
    logic [DATA_W-1:0] add_b;
    logic              add_ci;
    logic [DATA_W:0]   sum;
    logic              is_arith;
    logic [DATA_W-1:0] r;
    logic              known;
    logic              writes;
    logic              cf;

    assign is_arith = i_data.opcode inside {OP_SUB, OP_RSB, OP_ADD, OP_CMP};

    always_comb begin
        case (i_data.opcode)
            OP_RSB: begin
                add_a  = i_data.op2;
                add_b  = ~i_data.rn;
                add_ci = 1'b1;
            end
            OP_ADD: begin
                add_a  = i_data.rn;
                add_b  = i_data.op2;
                add_ci = 1'b0;
            end
            default: begin
                add_a  = i_data.rn;
                add_b  = ~i_data.op2;
                add_ci = 1'b1;
            end
        endcase
    end

    assign sum = {1'b0, add_a} + {1'b0, add_b} + {{DATA_W{1'b0}}, add_ci};

    always_comb begin
        known  = 1'b1;
        writes = 1'b1;
        case (i_data.opcode)
            OP_AND: r = i_data.rn & i_data.op2;
            OP_EOR: r = i_data.rn ^ i_data.op2;
            OP_SUB: r = sum[DATA_W-1:0];
            OP_RSB: r = sum[DATA_W-1:0];
            OP_ADD: r = sum[DATA_W-1:0];
            OP_TST: begin
                r      = i_data.rn & i_data.op2;
                writes = 1'b0;
            end
            OP_TEQ: begin
                r      = i_data.rn ^ i_data.op2;
                writes = 1'b0;
            end
            OP_CMP: begin
                r      = sum[DATA_W-1:0];
                writes = 1'b0;
            end
            OP_ORR: r = i_data.rn | i_data.op2;
            OP_MOV: r = i_data.op2;
            default: begin
                r      = '0;
                known  = 1'b0;
                writes = 1'b0;
            end
        endcase
    end

    assign cf = is_arith ? sum[DATA_W] : i_data.sc;

    always_comb begin
        n_data.executed      = i_data.exec;
        n_data.dest_register = i_data.rd;
        n_data.write_enable  = 1'b0;
        n_data.result_value  = '0;
        n_data.flags_out     = i_data.flags;
        if (i_data.exec && known) begin
            n_data.write_enable = writes;
            n_data.result_value = writes ? r : '0;
            if (i_data.s) begin
                n_data.flags_out = {r[DATA_W-1], (r == '0), cf, i_data.flags[FLAG_V]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    a_we_needs_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_data.write_enable |-> r_data.executed)
        else $error("register write on an item that did not execute");

    a_no_write_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_data.write_enable |-> r_data.result_value == '0)
        else $error("nonzero result without a register write");

    a_v_kept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_valid |=> r_data.flags_out[FLAG_V] == $past(i_data.flags[FLAG_V]))
        else $error("overflow flag changed");

endmodule
